// ===== sv/stdg_pkg.sv =====
// Shared types and constants for the sine tone duty generator.
// No dependencies; imported by stdg_div, stdg_mul and the top level.
package stdg_pkg;

    // Fixed system sizes
    localparam int SAMPLE_RATE = 600000;
    localparam int MAX_PERIOD  = 4096;
    localparam int DUTY_STEPS  = 250;
    localparam int PHASE_STEPS = 4096;   // power of two: phase*PHASE_STEPS is a shift

    // Field widths
    localparam int FREQ_W  = 20;
    localparam int VOL_W   = 9;
    localparam int DUTY_W  = 8;
    localparam int IDX_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W   = 20;

    localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
    localparam int PER_W = $clog2(MAX_PERIOD + 1);
    localparam int PH_W  = $clog2(PHASE_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 1'd1;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd200;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 9'd256;
    localparam logic [VOL_W-1:0]  VOL_MAX    = 9'd256;

    // Shared divider sizing
    localparam int DIV_DW = (SR_W > PH_W) ? SR_W : PH_W;
    localparam int DIV_VW = (FREQ_W > PER_W) ? FREQ_W : PER_W;
    localparam int DIV_CW = $clog2(DIV_DW + 1);
    localparam logic [DIV_DW-1:0] SR_WORD = DIV_DW'(SAMPLE_RATE) << (DIV_DW - SR_W);

    // Shared multiplier sizing
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // Sine polynomial coefficients, Q16
    localparam logic [MUL_W-1:0] SIN_C0 = 17'd307;
    localparam logic [MUL_W-1:0] SIN_C1 = 17'd5223;
    localparam logic [MUL_W-1:0] SIN_C2 = 17'd42334;
    localparam logic [MUL_W-1:0] SIN_C3 = 17'd102944;
    localparam logic [MUL_W-1:0] SIN_MID = 17'd32768;
    localparam logic [MUL_W-1:0] X_FULL  = 17'd65536;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
        logic [DIV_VW-1:0] rem_init;
        logic [DIV_DW-1:0] word;
        logic [DIV_VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/stdg_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on stdg_pkg (div_req_t, div_rsp_t, sizing constants).
module stdg_div
    import stdg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_VW-1:0] rem_reg, rem_next;
    logic [DIV_VW-1:0] dvs_reg, dvs_next;
    logic [DIV_DW-1:0] word_reg, word_next;
    logic [DIV_DW-1:0] quot_reg, quot_next;
    logic [DIV_VW:0]   rem_sh;
    logic [DIV_VW:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, word_reg[DIV_DW-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        word_next = word_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            dvs_next  = req.divisor;
            word_next = req.word;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_sub[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
            quot_next = {quot_reg[DIV_DW-2:0], ge};
            word_next = word_reg << 1;
            cnt_next  = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        word_reg <= word_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

// ===== sv/stdg_mul.sv =====
// Shared 17x17 multiplier with registered product.
// Depends on stdg_pkg (MUL_W, PROD_W).
module stdg_mul
    import stdg_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/sine_tone_duty_generator_core.sv =====
// Sine tone duty generator: one PWM duty word per tick word.
// A tick is accepted only in idle, and the next one only after the word is in the output register.
// Work per word: a period divide at a period start, a phase divide on the 1-bit/cycle divider
// (20 quotient bits for the period, 12 for the phase) and 7 passes through one multiplier.
// Reset (aresetn low, synchronous): frequency 200, volume 256, position and period zero.
// Depends on stdg_pkg, stdg_div, stdg_mul.
module sine_tone_duty_generator_core
    import stdg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // tick input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_tick,
    // duty output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_W-1:0]    m_duty_value,
    output logic [IDX_W-1:0]     m_sample_index,
    output logic                 m_period_end
);

    // Sequencer, one-hot
    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_PDIV   = 12'b0000_0000_0010,
        ST_QSTART = 12'b0000_0000_0100,
        ST_QDIV   = 12'b0000_0000_1000,
        ST_SQ     = 12'b0000_0001_0000,
        ST_H1     = 12'b0000_0010_0000,
        ST_H2     = 12'b0000_0100_0000,
        ST_H3     = 12'b0000_1000_0000,
        ST_H4     = 12'b0001_0000_0000,
        ST_MAG    = 12'b0010_0000_0000,
        ST_DUTY   = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Config and period state
    logic [FREQ_W-1:0] freq_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [PER_W-1:0]  latched_reg, latched_next;

    // Datapath holding registers
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [MUL_W-1:0]  x_reg, x_next;
    logic [MUL_W-1:0]  x2_reg, x2_next;
    logic [MUL_W-1:0]  sv_reg, sv_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;

    // Shared units
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [MUL_W-1:0]  prod_hi;   // product >> 16

    // Derived values
    logic [PER_W-1:0]  per_eff;
    logic [IDX_W-1:0]  pos_eff;
    logic              last;
    logic [FREQ_W-1:0] freq_eff;
    logic [PER_W-1:0]  per_clamp;
    logic [MUL_W-1:0]  x_comb;
    logic [15:0]       r4;
    logic [15:0]       mag;
    logic [VOL_W-1:0]  vol_cap;
    logic              out_free;

    stdg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    stdg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_hi = prod[16 +: MUL_W];

    // Latched period never reads as zero; position folds back if it ran past it
    assign per_eff = (latched_reg == '0) ? PER_W'(1) : latched_reg;
    assign pos_eff = ({1'b0, pos_reg} >= per_eff) ? '0 : pos_reg;
    assign last    = ({1'b0, pos_eff} + PER_W'(1)) == per_eff;

    assign freq_eff = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;

    // Quotient clamped to 1..MAX_PERIOD
    always_comb begin
        if (div_rsp.quot > DIV_DW'(MAX_PERIOD)) begin
            per_clamp = PER_W'(MAX_PERIOD);
        end else if (div_rsp.quot == '0) begin
            per_clamp = PER_W'(1);
        end else begin
            per_clamp = div_rsp.quot[PER_W-1:0];
        end
    end

    // Angle = phase << 4 (16-bit turn). Quadrant is phase[11:10], r*4 is phase[9:0] << 6.
    // Odd quadrants mirror: x = 65536 - r*4.
    assign r4     = {phase_reg[PH_W-3:0], 6'b0};
    assign x_comb = phase_reg[PH_W-2] ? (X_FULL - {1'b0, r4}) : {1'b0, r4};

    // Half-wave magnitude, y >> 1
    assign mag     = prod_hi[16:1];
    assign vol_cap = (vol_reg > VOL_MAX) ? VOL_MAX : vol_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        latched_next = latched_reg;
        phase_next   = phase_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        sv_next      = sv_reg;
        duty_next    = duty_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;

        div_req          = '0;
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_tick) begin
                    if (pos_reg == '0) begin
                        // period start: SAMPLE_RATE / frequency
                        div_req.start    = 1'b1;
                        div_req.iters    = DIV_CW'(SR_W);
                        div_req.rem_init = '0;
                        div_req.word     = SR_WORD;
                        div_req.divisor  = DIV_VW'(freq_eff);
                        state_next       = ST_PDIV;
                    end else begin
                        state_next = ST_QSTART;
                    end
                end
            end
            ST_PDIV: begin
                if (div_rsp.done) begin
                    latched_next = per_clamp;
                    state_next   = ST_QSTART;
                end
            end
            ST_QSTART: begin
                // phase = pos * 2^PH_W / period: seed remainder with pos, shift in zeros
                div_req.start    = 1'b1;
                div_req.iters    = DIV_CW'(PH_W);
                div_req.rem_init = DIV_VW'(pos_eff);
                div_req.word     = '0;
                div_req.divisor  = DIV_VW'(per_eff);
                state_next       = ST_QDIV;
            end
            ST_QDIV: begin
                if (div_rsp.done) begin
                    phase_next = div_rsp.quot[PH_W-1:0];
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                x_next     = x_comb;
                mul_en     = 1'b1;
                mul_a      = x_comb;
                mul_b      = x_comb;
                state_next = ST_H1;
            end
            ST_H1: begin
                x2_next    = prod_hi;
                mul_en     = 1'b1;
                mul_a      = SIN_C0;
                mul_b      = prod_hi;
                state_next = ST_H2;
            end
            ST_H2: begin
                mul_en     = 1'b1;
                mul_a      = SIN_C1 - prod_hi;
                mul_b      = x2_reg;
                state_next = ST_H3;
            end
            ST_H3: begin
                mul_en     = 1'b1;
                mul_a      = SIN_C2 - prod_hi;
                mul_b      = x2_reg;
                state_next = ST_H4;
            end
            ST_H4: begin
                mul_en     = 1'b1;
                mul_a      = SIN_C3 - prod_hi;
                mul_b      = x_reg;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                // offset sine: lower half-turn adds, upper half-turn subtracts
                sv_next    = phase_reg[PH_W-1] ? (SIN_MID - {1'b0, mag})
                                               : (SIN_MID + {1'b0, mag});
                mul_en     = 1'b1;
                mul_a      = MUL_W'(vol_cap);
                mul_b      = MUL_W'(DUTY_STEPS);
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                mul_en     = 1'b1;
                mul_a      = sv_reg;
                mul_b      = prod[MUL_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold here until the output register can take the word
                if (out_free) begin
                    duty_next    = prod[24 +: DUTY_W];
                    idx_next     = pos_eff;
                    pend_next    = last;
                    m_valid_next = 1'b1;
                    pos_next     = last ? '0 : pos_eff + IDX_W'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            latched_reg <= '0;
            freq_reg    <= FREQ_RESET;
            vol_reg     <= VOL_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
            latched_reg <= latched_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TONE_FREQ: freq_reg <= cfg_wr_data[FREQ_W-1:0];
                    REG_VOLUME:    vol_reg  <= cfg_wr_data[VOL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        phase_reg <= phase_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        sv_reg    <= sv_next;
        duty_reg  <= duty_next;
        idx_reg   <= idx_next;
        pend_reg  <= pend_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_duty_value   = duty_reg;
    assign m_sample_index = idx_reg;
    assign m_period_end   = pend_reg;

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_value < DUTY_W'(DUTY_STEPS))
        else $error("duty word out of range");

    a_pos_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (latched_reg != '0) |-> ({1'b0, pos_reg} < latched_reg))
        else $error("position ran past latched period");

    a_period_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_reg <= PER_W'(MAX_PERIOD))
        else $error("latched period above maximum");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_PDIV || state_reg == ST_QDIV))
        else $error("divider finished outside a divide step");

    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_tick) |=> state_reg != ST_IDLE)
        else $error("accepted tick did not start the sequencer");

endmodule
